[rtl/lrca_pkg.sv]
package lrca_pkg;
  localparam int unsigned NUM_CELLS_DEF = 1024;
  localparam int unsigned RUN_MAX = 255;
  localparam int unsigned CFG_SHIFT_RST = 6;
  localparam int unsigned CFG_CELLS_RST = 1024;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_ADDREF  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_BUSY   = 2'd2,
    ST_INVAL  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_CELL_SHIFT   = 1'b0,
    CFG_CELLS_IN_USE = 1'b1
  } cfg_idx_t;
endpackage

[rtl/lrca_ram.sv]
module lrca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/log_ring_cell_allocator_top.sv]
// Add reference and release read the handle cell's header, wait for the registered
// read data and adjust its reference count where allowed. A full allocate checks
// the head header, reads each free-run header the walk visits, marks the granted
// header and writes one per leftover run. Rejected requests finish earlier.
// One item at a time; in_ready stays low until the result beat is taken.
// Reset: synchronous active-low rst_n; after it a clearing pass over all NUM_CELLS
// headers zeroes them, during which no input beat is accepted.
module log_ring_cell_allocator_top
  import lrca_pkg::*;
#(
  parameter int unsigned NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [23:0] in_request_bytes,
  input  logic [9:0]  in_handle_cell,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [9:0]  out_granted_cell,
  output logic [7:0]  out_granted_cells,
  output logic [7:0]  out_ref_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int unsigned AW = $clog2(NUM_CELLS);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_HREAD, S_HWAIT, S_HCHK, S_WREAD, S_WWAIT,
    S_WSTEP, S_MARK, S_SPLIT, S_RREAD, S_RWAIT, S_RMW, S_OUT
  } state_t;

  state_t state_r;
  logic [4:0]  shift_r;
  logic [10:0] cells_r;
  logic [AW-1:0] head_r, w_r, idx_r;
  logic [NW-1:0] n_r, i_r, rem_r, pos_r;
  logic [8:0] req_r;
  logic [7:0] last_r;
  logic [1:0] kind_r;
  logic [23:0] bytes_r;
  logic [9:0] hc_r;
  logic [1:0] st_r;
  logic [9:0] gc_r;
  logic [7:0] gn_r, rc_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  lrca_ram #(.WIDTH(16), .DEPTH(NUM_CELLS)) u_hdr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  wire [7:0] rd_refs = rdata[15:8];
  wire [7:0] rd_len  = rdata[7:0];

  logic [4:0] s_eff;
  logic [24:0] bsum;
  logic [24:0] req_full;
  logic [NW-1:0] nclamp;

  always_comb begin
    s_eff = shift_r < 5'd2 ? 5'd2 : (shift_r > 5'd16 ? 5'd16 : shift_r);
    bsum = {1'b0, bytes_r} + ((25'd1 << s_eff) - 25'd1);
    req_full = bsum >> s_eff;
    if (cells_r == 11'd0) nclamp = NW'(1);
    else if ({21'd0, cells_r} > NUM_CELLS) nclamp = NW'(NUM_CELLS);
    else nclamp = NW'(cells_r);
  end

  logic [NW-1:0] wi, ni, inext;
  always_comb begin
    wi = NW'(w_r) + i_r;
    ni = n_r - NW'(w_r);
    inext = i_r + NW'(rd_len);
    if (inext > ni) inext = ni;
  end

  logic [NW-1:0] hpos;
  logic [7:0] val;
  always_comb begin
    hpos = NW'(head_r) + pos_r;
    val = rem_r > NW'(RUN_MAX) ? 8'(RUN_MAX) : rem_r[7:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_r;
    wdata = '0;
    raddr = idx_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_HCHK: begin
        if (rd_refs == 8'd0 && NW'(req_r) > n_r - NW'(w_r)) begin
          we = 1'b1;
          waddr = w_r;
          wdata = {8'd0, 8'(n_r - NW'(w_r))};
        end
      end
      S_MARK: begin
        we = 1'b1;
        waddr = w_r;
        wdata = {8'd1, req_r[7:0]};
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = hpos[AW-1:0];
        wdata = {8'd0, val};
      end
      S_RMW: begin
        waddr = hc_r[AW-1:0];
        if (kind_r == KIND_ADDREF && rd_refs != 8'd0 && rd_refs != 8'd255) begin
          we = 1'b1;
          wdata = {rd_refs + 8'd1, rd_len};
        end else if (kind_r == KIND_RELEASE && rd_refs != 8'd0) begin
          we = 1'b1;
          wdata = {rd_refs - 8'd1, rd_len};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      shift_r <= 5'(CFG_SHIFT_RST);
      cells_r <= 11'(CFG_CELLS_RST);
      head_r <= '0;
      idx_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CELL_SHIFT) shift_r <= cfg_data[4:0];
        else cells_r <= cfg_data;
      end
      case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + AW'(1);
          if (idx_r == AW'(NUM_CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= in_kind;
            bytes_r <= in_request_bytes;
            hc_r <= in_handle_cell;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          n_r <= nclamp;
          st_r <= ST_INVAL; gc_r <= '0; gn_r <= '0; rc_r <= '0;
          if (kind_r == KIND_ALLOC) begin
            if (bytes_r == 24'd0) state_r <= S_OUT;
            else if (req_full > 25'(RUN_MAX) || req_full > 25'(nclamp)) begin
              st_r <= ST_NOMEM; state_r <= S_OUT;
            end else begin
              req_r <= req_full[8:0];
              w_r <= NW'(head_r) < nclamp ? head_r : '0;
              idx_r <= NW'(head_r) < nclamp ? head_r : '0;
              state_r <= S_HREAD;
            end
          end else if (kind_r == KIND_UNUSED || {1'b0, hc_r} >= 11'(nclamp)) begin
            state_r <= S_OUT;
          end else begin
            idx_r <= hc_r[AW-1:0];
            state_r <= S_RREAD;
          end
        end
        S_HREAD: state_r <= S_HWAIT;
        S_HWAIT: state_r <= S_HCHK;
        S_HCHK: begin
          st_r <= ST_NOMEM;
          i_r <= '0;
          last_r <= '0;
          if (rd_refs != 8'd0) state_r <= S_OUT;
          else begin
            if (NW'(req_r) > n_r - NW'(w_r)) begin
              w_r <= '0; idx_r <= '0;
            end
            state_r <= S_WREAD;
          end
        end
        S_WREAD: state_r <= S_WWAIT;
        S_WWAIT: state_r <= S_WSTEP;
        S_WSTEP: begin
          last_r <= rd_len;
          if (rd_refs != 8'd0) begin
            state_r <= i_r < NW'(req_r) ? S_OUT : S_MARK;
          end else if (rd_len == 8'd0) begin
            i_r <= ni;
            last_r <= 8'd0;
            state_r <= ni < NW'(req_r) ? S_OUT : S_MARK;
          end else begin
            i_r <= inext;
            if (inext >= NW'(req_r) || NW'(w_r) + inext >= n_r) begin
              state_r <= inext < NW'(req_r) ? S_OUT : S_MARK;
            end else begin
              idx_r <= AW'(NW'(w_r) + inext);
              state_r <= S_WREAD;
            end
          end
        end
        S_MARK: begin
          head_r <= (wi - i_r + NW'(req_r)) >= n_r ?
                    AW'(NW'(w_r) + NW'(req_r) - n_r) : AW'(NW'(w_r) + NW'(req_r));
          rem_r <= last_r == 8'd0 ? '0 : i_r - NW'(req_r);
          pos_r <= '0;
          st_r <= ST_OK; gc_r <= 10'(w_r); gn_r <= req_r[7:0]; rc_r <= 8'd1;
          state_r <= NW'(req_r) < i_r ? S_SPLIT : S_OUT;
        end
        S_SPLIT: begin
          rem_r <= rem_r - NW'(val);
          pos_r <= pos_r + NW'(val);
          if (rem_r - NW'(val) == '0) state_r <= S_OUT;
        end
        S_RREAD: state_r <= S_RWAIT;
        S_RWAIT: state_r <= S_RMW;
        S_RMW: begin
          if (kind_r == KIND_ADDREF) begin
            if (rd_refs == 8'd0 || rd_refs == 8'd255) begin
              st_r <= ST_BUSY; rc_r <= rd_refs;
            end else begin
              st_r <= ST_OK; rc_r <= rd_refs + 8'd1;
            end
          end else if (rd_refs == 8'd0) begin
            st_r <= ST_INVAL;
          end else begin
            st_r <= ST_OK; rc_r <= rd_refs - 8'd1;
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = state_r == S_OUT;
  assign out_status = st_r;
  assign out_granted_cell = gc_r;
  assign out_granted_cells = gn_r;
  assign out_ref_count = rc_r;
endmodule

[bench/lrca_scoreboard.sv]
`timescale 1ns / 1ps
module lrca_scoreboard
  import lrca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [23:0] in_request_bytes,
  input  logic [9:0]  in_handle_cell,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [9:0]  out_granted_cell,
  input  logic [7:0]  out_granted_cells,
  input  logic [7:0]  out_ref_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          n_ok,
  output int          n_nomem,
  output int          n_busy,
  output int          n_inval
);
  typedef struct packed {
    status_t    status;
    logic [9:0] first_cell;
    logic [7:0] cells;
    logic [7:0] refs;
  } grant_t;

  grant_t     expected_q[$];
  logic [4:0] shift_reg;
  logic [10:0] cells_reg;
  logic [7:0] refs_mem [NUM_CELLS_DEF];
  logic [7:0] len_mem [NUM_CELLS_DEF];
  int unsigned head;

  function automatic int unsigned span();
    int unsigned n;
    n = cells_reg;
    if (n < 1) n = 1;
    if (n > NUM_CELLS_DEF) n = NUM_CELLS_DEF;
    return n;
  endfunction

  function automatic grant_t mk(status_t st, int unsigned c, int unsigned k, int unsigned r);
    grant_t g;
    g.status = st;
    g.first_cell = c[9:0];
    g.cells = k[7:0];
    g.refs = r[7:0];
    return g;
  endfunction

  function automatic grant_t allocate(logic [23:0] bytes);
    int unsigned n, s, req, h, w, i, last, rem, offs, val;
    longint unsigned r64;
    n = span();
    s = shift_reg;
    i = 0;
    last = 0;
    if (s < 2) s = 2;
    if (s > 16) s = 16;
    if (bytes == 0) return mk(ST_INVAL, 0, 0, 0);
    r64 = (longint'(bytes) + ((64'd1 << s) - 1)) >> s;
    if (r64 > RUN_MAX || r64 > n) return mk(ST_NOMEM, 0, 0, 0);
    req = 32'(r64);
    h = head < n ? head : 0;
    if (refs_mem[h] != 0) return mk(ST_NOMEM, 0, 0, 0);
    if (req > n - h) begin
      refs_mem[h] = 8'd0;
      len_mem[h] = 8'(n - h);
      w = 0;
    end else begin
      w = h;
    end
    while (i < req) begin
      if (w + i >= n || refs_mem[w + i] != 0) break;
      last = len_mem[w + i];
      if (last == 0) begin
        i = n - w;
        break;
      end
      i += last;
      if (i > n - w) i = n - w;
    end
    if (i < req) return mk(ST_NOMEM, 0, 0, 0);
    refs_mem[w] = 8'd1;
    len_mem[w] = 8'(req);
    head = (w + req) % n;
    if (req < i) begin
      rem = (last == 0) ? 0 : i - req;
      offs = 0;
      do begin
        val = rem > RUN_MAX ? RUN_MAX : rem;
        refs_mem[head + offs] = 8'd0;
        len_mem[head + offs] = 8'(val);
        rem -= val;
        offs += val;
      end while (rem > 0);
    end
    return mk(ST_OK, w, req, 1);
  endfunction

  function automatic grant_t apply_item(kind_t k, logic [23:0] bytes, logic [9:0] c);
    if (k == KIND_ALLOC) return allocate(bytes);
    if (k == KIND_UNUSED || c >= span()) return mk(ST_INVAL, 0, 0, 0);
    if (k == KIND_ADDREF) begin
      if (refs_mem[c] == 0 || refs_mem[c] == 255) return mk(ST_BUSY, 0, 0, refs_mem[c]);
      refs_mem[c]++;
      return mk(ST_OK, 0, 0, refs_mem[c]);
    end
    if (refs_mem[c] == 0) return mk(ST_INVAL, 0, 0, 0);
    refs_mem[c]--;
    return mk(ST_OK, 0, 0, refs_mem[c]);
  endfunction

  always @(posedge clk) begin
    grant_t e;
    if (!rst_n) begin
      shift_reg = 5'(CFG_SHIFT_RST);
      cells_reg = 11'(CFG_CELLS_RST);
      head = 0;
      for (int j = 0; j < NUM_CELLS_DEF; j++) begin
        refs_mem[j] = 8'd0;
        len_mem[j] = 8'd0;
      end
      expected_q.delete();
      fail_count = 0;
      pending = 0;
      n_ok = 0;
      n_nomem = 0;
      n_busy = 0;
      n_inval = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CELL_SHIFT) shift_reg = cfg_data[4:0];
        else cells_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status);
            fail_count++;
          end
          if (out_granted_cell !== e.first_cell) begin
            $error("granted_cell: expected %0d actual %0d", e.first_cell, out_granted_cell);
            fail_count++;
          end
          if (out_granted_cells !== e.cells) begin
            $error("granted_cells: expected %0d actual %0d", e.cells, out_granted_cells);
            fail_count++;
          end
          if (out_ref_count !== e.refs) begin
            $error("ref_count: expected %0d actual %0d", e.refs, out_ref_count);
            fail_count++;
          end
          case (e.status)
            ST_OK:    n_ok++;
            ST_NOMEM: n_nomem++;
            ST_BUSY:  n_busy++;
            default:  n_inval++;
          endcase
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_item(kind_t'(in_kind), in_request_bytes, in_handle_cell));
      pending = expected_q.size();
    end
  end
endmodule

[bench/log_ring_cell_allocator_top_tb.sv]
`timescale 1ns / 1ps
module log_ring_cell_allocator_top_tb;
  import lrca_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [23:0] in_request_bytes;
  logic [9:0]  in_handle_cell;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [9:0]  out_granted_cell;
  logic [7:0]  out_granted_cells;
  logic [7:0]  out_ref_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [10:0] cfg_data;
  int          fail_count, pending, n_ok, n_nomem, n_busy, n_inval;
  int          items_sent;
  int          hold_off;
  int          rx_wait;
  bit          beat_due;
  longint      cycle_count;
  logic [9:0]  grants_q[$];
  int unsigned cur_cells;

  log_ring_cell_allocator_top u_top (.*);

  lrca_scoreboard u_scoreboard (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 20000000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic rdy;
    out_ready = 0;
    hold_off = 0;
    rx_wait = 0;
    beat_due = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (beat_due) rx_wait = $urandom_range(0, 9);
      if (hold_off > 0) begin
        rdy = 0;
        hold_off--;
      end else if (rx_wait > 0) begin
        rdy = 0;
        rx_wait--;
      end else begin
        rdy = 1;
      end
      out_ready <= rdy;
      beat_due = out_valid && rdy;
    end
  end

  task automatic send_item(kind_t k, logic [23:0] b, logic [9:0] c, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 9) : 0;
    repeat (wait_n) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= k;
    in_request_bytes <= b;
    in_handle_cell <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0 || in_valid) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
    if (idx == CFG_CELLS_IN_USE) begin
      cur_cells = val == 0 ? 1 : (val > 1024 ? 1024 : val);
      grants_q.delete();
    end
  endtask

  function automatic logic [23:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(1, 64));
      1: return 24'($urandom_range(1, 4096));
      2: return 24'($urandom_range(1, 20000));
      3: return 24'($urandom);
      4: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [9:0] c;
    r = $urandom_range(0, 99);
    if (grants_q.size() > 0 && $urandom_range(0, 9) < 7)
      c = grants_q[$urandom_range(0, grants_q.size() - 1)];
    else c = 10'($urandom);
    if (r < 45) send_item(KIND_ALLOC, rand_bytes(), 10'($urandom), 1);
    else if (r < 70) send_item(KIND_RELEASE, 24'($urandom), c, 1);
    else if (r < 95) send_item(KIND_ADDREF, 24'($urandom), c, 1);
    else send_item(KIND_UNUSED, 24'($urandom), 10'($urandom), 1);
    if (r < 45 && grants_q.size() < 64)
      grants_q.push_back(10'($urandom_range(0, cur_cells - 1)));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_kind = KIND_ALLOC;
    in_request_bytes = 0;
    in_handle_cell = 0;
    cfg_valid = 0;
    cfg_index = CFG_CELL_SHIFT;
    cfg_data = 0;
    items_sent = 0;
    cur_cells = 1024;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_item(KIND_ALLOC, 0, 0, 0);
    send_item(KIND_ALLOC, 1, 0, 0);
    send_item(KIND_ALLOC, 24'hFFFFFF, 0, 0);
    send_item(KIND_ALLOC, 255 * 64, 0, 0);
    send_item(KIND_ADDREF, 0, 0, 0);
    send_item(KIND_ADDREF, 0, 1, 0);
    send_item(KIND_RELEASE, 0, 0, 0);
    send_item(KIND_RELEASE, 0, 0, 0);
    send_item(KIND_RELEASE, 0, 0, 0);
    send_item(KIND_ADDREF, 24'hFFFFFF, 10'h3FF, 0);
    send_item(KIND_UNUSED, 24'hFFFFFF, 10'h3FF, 0);
    for (int j = 0; j < 256; j++) send_item(KIND_ADDREF, 0, 1, j < 4);
    for (int j = 0; j < 6; j++) send_item(KIND_ALLOC, 200 * 64, 0, 0);
    send_item(KIND_ALLOC, 64 * 30, 0, 0);
    drain();

    write_reg(CFG_CELL_SHIFT, 0);
    write_reg(CFG_CELLS_IN_USE, 0);
    send_item(KIND_ALLOC, 4, 0, 0);
    send_item(KIND_ALLOC, 4, 0, 0);
    send_item(KIND_RELEASE, 0, 0, 0);
    send_item(KIND_ALLOC, 5, 0, 0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_CELL_SHIFT, 16); write_reg(CFG_CELLS_IN_USE, 1024); end
        1: begin write_reg(CFG_CELL_SHIFT, 31); write_reg(CFG_CELLS_IN_USE, 11'h7FF); end
        2: begin write_reg(CFG_CELL_SHIFT, 2); write_reg(CFG_CELLS_IN_USE, 300); end
        3: begin write_reg(CFG_CELL_SHIFT, 6); write_reg(CFG_CELLS_IN_USE, 2); end
        4: begin write_reg(CFG_CELL_SHIFT, 8); write_reg(CFG_CELLS_IN_USE, 40); end
        5: begin write_reg(CFG_CELL_SHIFT, 1); write_reg(CFG_CELLS_IN_USE, 600); end
        6: begin write_reg(CFG_CELL_SHIFT, 10); write_reg(CFG_CELLS_IN_USE, 1); end
        default: begin write_reg(CFG_CELL_SHIFT, 5); write_reg(CFG_CELLS_IN_USE, 700); end
      endcase
      for (int j = 0; j < 200; j++) begin
        if (phase == 2 && j == 50) hold_off = 300;
        if (phase == 4 && j == 100) begin
          in_valid <= 0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
      drain();
    end

    $display("Covered %0d items over 10 settings: %0d ok, %0d no-memory, %0d busy, %0d invalid",
             items_sent, n_ok, n_nomem, n_busy, n_inval);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
